### rtl/ope_pkg.sv
// Shared types, constants and SHA-256 helper functions for the ORE prefix encoder.
package ope_pkg;

	localparam int PLAIN_BITS_DEF = 32;
	localparam int CFG_IDX_W      = 8;
	localparam int KEY_WORDS      = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 8'd3;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;
	localparam logic [7:0] PAD_MARK  = 8'h80;

	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_ROUND [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [31:0] plaintext;
		logic [4:0]  bit_index;
	} in_t;

	typedef struct packed {
		logic [63:0] code_word_0;
		logic [63:0] code_word_1;
		logic [63:0] code_word_2;
		logic [63:0] code_word_3;
	} out_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

### rtl/ore_prefix_hmac_encode_top.sv
// Top level of the ORE prefix encoder: HMAC-SHA256 of a bit-position prefix plus the next bit.
//
// Each accepted item (plaintext, bit_index) yields one 256-bit code word equal to
// HMAC-SHA256(key, be32(i) || prefix bytes) plus the plaintext's next bit, mod 2^256.
// The datapath is three SHA-256 compressions deep, each a row of 64 round cells
// followed by a feed-forward stage: the inner key block and the outer key block
// are compressed side by side, then the inner message block, then the outer
// digest block, then one stage adds the bit. One item enters per cycle unless the
// output stalls: the whole chain moves together whenever the output register is
// empty or being taken, so in_ready is simply !out_valid || out_ready and
// sustained throughput is one item per clock. The key is written through
// cfg_we/cfg_index/cfg_data (index 0..3 = key words, other indexes ignored);
// the user must write it only while no item is in flight, as the block itself does
// not enforce this. Key words are used live by the first compressions.
module ore_prefix_hmac_encode_top import ope_pkg::*; #(
	parameter int PLAIN_BITS = PLAIN_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int NB = (PLAIN_BITS + 7) / 8;
	localparam logic [63:0] INNER_LEN_BITS = 64'((64 + 4 + NB) * 8);
	localparam logic [63:0] OUTER_LEN_BITS = 64'(96 * 8);

	logic [63:0] key_q [KEY_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_WORDS; k++) begin
				key_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_WORD_0: key_q[0] <= cfg_data;
				CFG_KEY_WORD_1: key_q[1] <= cfg_data;
				CFG_KEY_WORD_2: key_q[2] <= cfg_data;
				CFG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole chain advances together; output register parts the sides
	logic en;
	logic out_valid_q;
	out_t out_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// key pads
	logic [511:0] key_blk, ipad_blk, opad_blk;
	assign key_blk  = {key_q[0], key_q[1], key_q[2], key_q[3], 256'b0};
	assign ipad_blk = key_blk ^ {64{IPAD_BYTE}};
	assign opad_blk = key_blk ^ {64{OPAD_BYTE}};

	// prefix message block
	logic [7:0]   pb [8];
	logic [1:0]   full;
	logic [2:0]   off;
	logic         nbit;
	logic [511:0] msg_blk;
	logic [7:0]   byte_v;

	always_comb begin
		full = in_data.bit_index[4:3];
		off  = in_data.bit_index[2:0];
		// bytes above bit 31 read as zero
		for (int k = 0; k < 8; k++) begin
			pb[k] = 8'(64'(in_data.plaintext) >> (8 * k));
		end
		msg_blk = '0;
		msg_blk[511:480] = {27'b0, in_data.bit_index};
		for (int t = 0; t < NB; t++) begin
			byte_v = pb[NB-1-t];
			if (t < int'(full)) begin
				msg_blk[479 - 8*t -: 8] = byte_v;
			end else if (t == int'(full)) begin
				// partial byte: top off bits right-aligned, empty when off is zero
				msg_blk[479 - 8*t -: 8] = byte_v >> (4'd8 - {1'b0, off});
			end
		end
		msg_blk[479 - 8*NB -: 8] = PAD_MARK;
		msg_blk[63:0] = INNER_LEN_BITS;
		nbit = 1'b0;
		if (int'(full) < NB) begin
			nbit = pb[NB-1-int'(full)][3'd7 - off];
		end
	end

	// stage 1: inner and outer key blocks in parallel
	logic         v1, v3;
	logic [255:0] h1, h3;
	logic [511:0] msg_s1;
	logic         bit_s1;

	ope_compress #(.SIDE_W(512)) u_inner_key (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(in_valid && in_ready), .hin_i(SHA_IV), .blk_i(ipad_blk), .side_i(msg_blk),
		.valid_o(v1), .hout_o(h1), .side_o(msg_s1)
	);

	ope_compress #(.SIDE_W(1)) u_outer_key (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(in_valid && in_ready), .hin_i(SHA_IV), .blk_i(opad_blk), .side_i(nbit),
		.valid_o(v3), .hout_o(h3), .side_o(bit_s1)
	);

	// stage 2: inner message block, carrying the outer midstate
	logic         v2;
	logic [255:0] h2;
	logic [256:0] side_s2;

	ope_compress #(.SIDE_W(257)) u_inner_msg (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(v1 && v3), .hin_i(h1), .blk_i(msg_s1), .side_i({bit_s1, h3}),
		.valid_o(v2), .hout_o(h2), .side_o(side_s2)
	);

	// stage 3: outer block over the inner digest
	logic         v4;
	logic [255:0] h4;
	logic         bit_s3;
	logic [511:0] dig_blk;
	assign dig_blk = {h2, PAD_MARK, 184'b0, OUTER_LEN_BITS};

	ope_compress #(.SIDE_W(1)) u_outer_dig (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(v2), .hin_i(side_s2[255:0]), .blk_i(dig_blk), .side_i(side_s2[256]),
		.valid_o(v4), .hout_o(h4), .side_o(bit_s3)
	);

	// final add of the next bit, mod 2^256
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_t'(h4 + {255'b0, bit_s3});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/ope_round_cell.sv
// One SHA-256 round cell with its rolling 16-word message schedule window.
module ope_round_cell import ope_pkg::*; #(
	parameter int ROUND  = 0,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  logic [255:0]      st_i,
	input  logic [511:0]      win_i,
	input  logic [255:0]      hin_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              valid_o,
	output logic [255:0]      st_o,
	output logic [511:0]      win_o,
	output logic [255:0]      hin_o,
	output logic [SIDE_W-1:0] side_o
);

	logic [31:0] a, b, c, d, e, f, g, h;
	logic [31:0] t1, t2, w_new;
	logic [255:0] st_nxt;
	logic valid_q;
	logic [255:0] st_q, hin_q;
	logic [511:0] win_q;
	logic [SIDE_W-1:0] side_q;

	assign {a, b, c, d, e, f, g, h} = st_i;

	always_comb begin
		t1 = h + big_sig1(e) + ((e & f) ^ (~e & g)) + K_ROUND[ROUND] + win_i[511:480];
		t2 = big_sig0(a) + ((a & b) ^ (a & c) ^ (b & c));
		st_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
		// w[t+16] = w[t] + s0(w[t+1]) + w[t+9] + s1(w[t+14])
		w_new = win_i[511:480] + sml_sig0(win_i[479:448]) + win_i[223:192]
			+ sml_sig1(win_i[63:32]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q   <= st_nxt;
			win_q  <= {win_i[479:0], w_new};
			hin_q  <= hin_i;
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign st_o    = st_q;
	assign win_o   = win_q;
	assign hin_o   = hin_q;
	assign side_o  = side_q;

endmodule

### rtl/ope_compress.sv
// SHA-256 compression as a chain of 64 round cells plus a feed-forward stage.
module ope_compress import ope_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  logic [255:0]      hin_i,
	input  logic [511:0]      blk_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              valid_o,
	output logic [255:0]      hout_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int ROUNDS = 64;

	logic              vld  [ROUNDS+1];
	logic [255:0]      st   [ROUNDS+1];
	logic [511:0]      win  [ROUNDS+1];
	logic [255:0]      hin  [ROUNDS+1];
	logic [SIDE_W-1:0] side [ROUNDS+1];

	logic              valid_q;
	logic [255:0]      hout_q;
	logic [SIDE_W-1:0] side_q;
	logic [255:0]      hsum;

	assign vld[0]  = valid_i;
	assign st[0]   = hin_i;
	assign win[0]  = blk_i;
	assign hin[0]  = hin_i;
	assign side[0] = side_i;

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		ope_round_cell #(.ROUND(r), .SIDE_W(SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (vld[r]),
			.st_i    (st[r]),
			.win_i   (win[r]),
			.hin_i   (hin[r]),
			.side_i  (side[r]),
			.valid_o (vld[r+1]),
			.st_o    (st[r+1]),
			.win_o   (win[r+1]),
			.hin_o   (hin[r+1]),
			.side_o  (side[r+1])
		);
	end

	// chaining value feed-forward, word by word
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			hsum[j*32 +: 32] = st[ROUNDS][j*32 +: 32] + hin[ROUNDS][j*32 +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vld[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hout_q <= hsum;
			side_q <= side[ROUNDS];
		end
	end

	assign valid_o = valid_q;
	assign hout_o  = hout_q;
	assign side_o  = side_q;

endmodule

### rtl/ope_checker.sv
// Port-level checker for the ORE prefix encoder, bound to the top level.
module ope_checker import ope_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// a stalled output blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("item accepted while output stalled");

	// empty output register always takes items
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// pipeline is deep: no result right after reset
	a_no_early_out: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result right after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");

endmodule

bind ore_prefix_hmac_encode_top ope_checker u_ope_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### test/tb.sv
// Testbench for ore_prefix_hmac_encode_top: a self-built HMAC-SHA256 predictor checks every code word.
module tb;
	import ope_pkg::*;

	// Clock, reset and block ports.
	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	ore_prefix_hmac_encode_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Settle margin after the last code word.
	localparam int SETTLE_CYCLES = 240;
	// Long receiver hold-off, well past the pipeline depth so in_ready drops.
	localparam int HOLD_CYCLES   = 700;
	localparam int RANDOM_ITEMS  = 1100;

	// Our copy of the key, {word0, word1, word2, word3}, key byte 0 at the top.
	logic [255:0] hmac_key;
	out_t         code_q[$];
	int           mismatch_cnt;
	bit           calm;          // no idling on either side while set
	int           hold_req;      // bumped by the stimulus to ask for a long hold-off
	int           hold_seen;
	int           hold_left;

	// SHA-256 round constants.
	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	// One compression of a 512-bit block into the chaining state.
	function automatic logic [255:0] sha_block(input logic [255:0] hs, input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = blk[511 - 32 * t -: 32];
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		{a, b, c, d, e, f, g, h} = hs;
		for (int t = 0; t < 64; t++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[t] + w[t];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		return {hs[255:224] + a, hs[223:192] + b, hs[191:160] + c, hs[159:128] + d,
			hs[127:96] + e, hs[95:64] + f, hs[63:32] + g, hs[31:0] + h};
	endfunction

	// SHA-256 of the first len bytes of data (byte 0 at the top), len <= 96.
	function automatic logic [255:0] sha_digest(input logic [767:0] data, input int len);
		logic [1535:0] padded;
		logic [255:0]  hs;
		logic [63:0]   nbits;
		int            total;
		padded = '0;
		for (int j = 0; j < len; j++)
			padded[1535 - 8 * j -: 8] = data[767 - 8 * j -: 8];
		padded[1535 - 8 * len -: 8] = 8'h80;
		total = ((len + 8) / 64 + 1) * 64;
		nbits = 64'(len) * 8;
		for (int j = 0; j < 8; j++)
			padded[1535 - 8 * (total - 1 - j) -: 8] = nbits[8 * j +: 8];
		hs = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		for (int blk = 0; blk < total / 64; blk++)
			hs = sha_block(hs, padded[1535 - 512 * blk -: 512]);
		return hs;
	endfunction

	// Code word for one bit position: HMAC of be32(i) || prefix bytes, plus the next bit.
	function automatic out_t encode_position(input in_t item, input logic [255:0] key);
		logic [63:0]  msg;
		logic [7:0]   cur;
		logic [511:0] kblk;
		logic [255:0] inner, digest;
		int           full, off;
		logic         nbit;
		out_t         res;
		full = item.bit_index / 8;
		off  = item.bit_index % 8;
		msg  = '0;
		msg[63:32] = 32'(item.bit_index);
		// Whole prefix bytes, most significant plaintext byte first.
		for (int t = 0; t < full; t++)
			msg[31 - 8 * t -: 8] = item.plaintext[8 * (3 - t) +: 8];
		// Partial byte right-aligned; the next bit comes from the same byte.
		// With a 5-bit index the prefix never runs past the plaintext.
		cur = item.plaintext[8 * (3 - full) +: 8];
		if (off != 0)
			msg[31 - 8 * full -: 8] = cur >> (8 - off);
		nbit = cur[7 - off];
		kblk  = {key, 256'b0};
		inner = sha_digest({kblk ^ {64{8'h36}}, msg, 192'b0}, 72);
		digest = sha_digest({kblk ^ {64{8'h5c}}, inner}, 96);
		// Wraps modulo 2^256 when the digest is all ones.
		digest = digest + 256'(nbit);
		res.code_word_0 = digest[255:192];
		res.code_word_1 = digest[191:128];
		res.code_word_2 = digest[127:64];
		res.code_word_3 = digest[63:0];
		return res;
	endfunction

	// Clock: period 10.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: out_ready changes at the falling edge; random idling plus
	// the long hold-off when the stimulus asks for one.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 12) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result check at the rising edge against the oldest expected code word.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (code_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected code word %h", out_data);
			end else begin
				want = code_q.pop_front();
				if (out_data.code_word_0 !== want.code_word_0 ||
					out_data.code_word_1 !== want.code_word_1 ||
					out_data.code_word_2 !== want.code_word_2 ||
					out_data.code_word_3 !== want.code_word_3) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("code word mismatch: expected %h got %h", want, out_data);
				end
			end
		end
	end

	// Offer one item, with random idle cycles in front, and hold it until taken.
	task automatic send_item(input in_t item);
		while (!calm && $urandom_range(0, 99) < 12) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (!in_ready);
		code_q.push_back(encode_position(item, hmac_key));
	endtask

	// Stop offering, wait for every code word, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (code_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Key write; indexes above the last key word must be ignored by the block.
	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_KEY_WORD_0: hmac_key[255:192] = val;
			CFG_KEY_WORD_1: hmac_key[191:128] = val;
			CFG_KEY_WORD_2: hmac_key[127:64]  = val;
			CFG_KEY_WORD_3: hmac_key[63:0]    = val;
			default: ;
		endcase
	endtask

	task automatic write_whole_key(input logic [255:0] key);
		write_key(CFG_KEY_WORD_0, key[255:192]);
		write_key(CFG_KEY_WORD_1, key[191:128]);
		write_key(CFG_KEY_WORD_2, key[127:64]);
		write_key(CFG_KEY_WORD_3, key[63:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic in_t random_item();
		in_t it;
		case ($urandom_range(0, 7))
			0: it.plaintext = '0;
			1: it.plaintext = '1;
			2: it.plaintext = 32'h1 << $urandom_range(0, 31);
			default: it.plaintext = $urandom;
		endcase
		it.bit_index = 5'($urandom_range(0, 31));
		return it;
	endfunction

	// Directed rows: field extremes, every byte boundary of the index,
	// next bit set and clear, partial and whole prefix bytes.
	in_t dir_rows[$];

	initial begin
		logic [255:0] next_key;
		int           phase_items;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		hmac_key     = '0;
		mismatch_cnt = 0;
		calm         = 1'b0;
		hold_req     = 0;
		hold_seen    = 0;
		hold_left    = 0;
		arst_n       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_rows = '{
			'{32'h00000000, 5'd0},  '{32'hffffffff, 5'd0},  '{32'h00000000, 5'd31},
			'{32'hffffffff, 5'd31}, '{32'h80000000, 5'd0},  '{32'h7fffffff, 5'd0},
			'{32'h00000001, 5'd31}, '{32'hfffffffe, 5'd31}, '{32'hdeadbeef, 5'd7},
			'{32'hdeadbeef, 5'd8},  '{32'hdeadbeef, 5'd15}, '{32'hdeadbeef, 5'd16},
			'{32'hdeadbeef, 5'd23}, '{32'hdeadbeef, 5'd24}, '{32'h12345678, 5'd1},
			'{32'h12345678, 5'd9},  '{32'h12345678, 5'd17}, '{32'h12345678, 5'd25},
			'{32'haaaaaaaa, 5'd12}, '{32'h55555555, 5'd12}, '{32'h00ff00ff, 5'd20}
		};

		// Directed part under the reset key of all zeros.
		foreach (dir_rows[k])
			send_item(dir_rows[k]);
		drain();

		// Key of all ones, plus writes to unused indexes that must leave it alone.
		write_whole_key('1);
		write_key(8'd4, 64'h0123456789abcdef);
		write_key(8'hff, '0);
		@(negedge clk);
		cfg_we <= 1'b0;
		foreach (dir_rows[k])
			send_item(dir_rows[k]);
		drain();

		// Random phases, each under a fresh key; one quiet phase, one long hold-off.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: next_key = '0;
				1: next_key = {8{32'haaaa5555}};
				default: next_key = {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
			endcase
			write_whole_key(next_key);
			calm = (phase == 2);
			if (phase == 3)
				hold_req++;
			phase_items = RANDOM_ITEMS / 6;
			for (int n = 0; n < phase_items; n++) begin
				send_item(random_item());
				// Sender pause until every code word so far has come back.
				if (phase == 4 && n == phase_items / 2) begin
					@(negedge clk);
					in_valid <= 1'b0;
					while (code_q.size() != 0)
						@(posedge clk);
				end
			end
			drain();
			calm = 1'b0;
		end

		if (mismatch_cnt == 0 && code_q.size() == 0) begin
			$display("PASS ore_prefix_hmac_encode_top");
		end else begin
			$display("FAIL ore_prefix_hmac_encode_top");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#20000000;
		$display("FAIL ore_prefix_hmac_encode_top");
		$finish;
	end

endmodule

### filelist.f
rtl/ope_pkg.sv
rtl/ope_round_cell.sv
rtl/ope_compress.sv
rtl/ore_prefix_hmac_encode_top.sv
rtl/ope_checker.sv
test/tb.sv
